// ===== design/iad_pkg.sv =====
`default_nettype none

package iad_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 7;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int LEN_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

	localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESIZE = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         new_length;
	} iad_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic [STAT_W-1:0]        status;
		logic [POS_W-1:0]         length;
	} iad_res_t;

	typedef struct packed {
		logic             wr;
		logic             ins;
		logic             del;
		logic [CMP_W-1:0] pos;
		logic [CMP_W-1:0] len;
		word_t            value;
	} iad_ctl_t;

endpackage

`default_nettype wire

// ===== design/iad_cell.sv =====
`default_nettype none

module iad_cell
	import iad_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] idx,
	input  wire iad_ctl_t         ctl,
	input  wire word_t            left,
	input  wire word_t            right,
	output      word_t            word,
	output      word_t            rd
);

	word_t            word_q;
	logic [CMP_W-1:0] idx_x;
	logic             at_pos;
	logic             take_left;
	logic             take_right;

	assign idx_x      = CMP_W'(idx);
	assign at_pos     = (idx_x == ctl.pos);
	assign take_left  = ctl.ins && (idx_x > ctl.pos) && (idx_x <= ctl.len);
	assign take_right = ctl.del && (idx_x >= ctl.pos) && ((idx_x + 1'b1) < ctl.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if ((ctl.wr || ctl.ins) && at_pos) begin
			word_q <= ctl.value;
		end else if (take_left) begin
			word_q <= left;
		end else if (take_right) begin
			word_q <= right;
		end
	end

	assign word = word_q;
	assign rd   = at_pos ? word_q : '0;

endmodule

`default_nettype wire

// ===== design/indexed_array_insert_delete.sv =====
// Bounded ordered array of signed words with a current length.
// Command channel: request is taken at a rising edge where start is high
// and busy is low. busy stays low, so a command may be issued every cycle.
// Commands: read, write, insert (shift later entries up), delete (shift
// later entries down) and resize. Every command yields one result.
// Result channel: result is valid for exactly one cycle while done is high,
// in the cycle after the command is taken. Throughput 1 item per cycle;
// each item is finished by the row of storage cells, which all load, hold
// or take a neighbour's word at the edge where the command is taken.
// Rejected requests (out of range, full, unknown command) change nothing
// and report a non-zero status with read_data zero.
// Reset clears every entry to zero, the length to zero and drops done.
// The receiver cannot stall: a result not taken in its cycle is lost.
`default_nettype none

module indexed_array_insert_delete
	import iad_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output      logic     busy,
	input  wire iad_req_t request,
	output      logic     done,
	output      iad_res_t result
);

	logic [LEN_W-1:0] len_q;
	logic             done_q;
	iad_res_t         result_q;

	logic             accept;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] len_x;
	logic [CMP_W-1:0] nlen_x;
	logic             in_range;
	iad_ctl_t         ctl;
	logic [STAT_W-1:0] status;
	logic [LEN_W-1:0] len_next;
	logic             rd_ok;

	word_t words [DEPTH];
	word_t lefts [DEPTH];
	word_t rights [DEPTH];
	word_t rds [DEPTH];
	word_t rd_word;

	assign accept = start && !busy;
	assign busy   = 1'b0;
	assign pos_x  = CMP_W'(request.position);
	assign len_x  = CMP_W'(len_q);
	assign nlen_x = CMP_W'(request.new_length);
	assign in_range = pos_x < len_x;

	always_comb begin
		ctl       = '0;
		ctl.pos   = pos_x;
		ctl.len   = len_x;
		ctl.value = request.value[WORD_BITS-1:0];
		status    = ST_OK;
		len_next  = len_q;
		rd_ok     = 1'b0;
		case (request.command)
			CMD_READ: begin
				if (in_range) rd_ok = 1'b1;
				else status = ST_RANGE;
			end
			CMD_WRITE: begin
				if (in_range) ctl.wr = accept;
				else status = ST_RANGE;
			end
			CMD_INSERT: begin
				if (pos_x > len_x) begin
					status = ST_RANGE;
				end else if (len_x >= CMP_W'(DEPTH)) begin
					status = ST_FULL;
				end else begin
					ctl.ins  = accept;
					len_next = len_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (in_range) begin
					ctl.del  = accept;
					len_next = len_q - 1'b1;
				end else begin
					status = ST_RANGE;
				end
			end
			CMD_RESIZE: begin
				if (nlen_x <= CMP_W'(DEPTH)) len_next = LEN_W'(nlen_x);
				else status = ST_RANGE;
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign lefts[g] = '0;
		end else begin : g_left
			assign lefts[g] = words[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign rights[g] = '0;
		end else begin : g_right
			assign rights[g] = words[g+1];
		end
		iad_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.idx   (IDX_W'(g)),
			.ctl   (ctl),
			.left  (lefts[g]),
			.right (rights[g]),
			.word  (words[g]),
			.rd    (rds[g])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | rds[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) len_q <= len_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.read_data <= rd_ok ? DATA_W'(signed'(rd_word)) : '0;
			result_q.status    <= status;
			result_q.length    <= POS_W'(len_next);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== design/iad_checker.sv =====
`default_nettype none

module iad_checker
	import iad_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire iad_req_t request,
	input wire logic     done,
	input wire iad_res_t result
);

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("missing result after accepted item");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without accepted item");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.read_data == '0))
		else $error("rejected item carries read data");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (CMP_W'(result.length) <= CMP_W'(DEPTH)))
		else $error("length beyond depth");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> (CMP_W'(result.length) == CMP_W'(DEPTH)))
		else $error("full status with spare room");

endmodule

bind indexed_array_insert_delete iad_checker u_iad_checker (.*);

`default_nettype wire

// ===== dv/iad_array_checker.sv =====
`default_nettype none

module iad_array_checker
	import iad_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       busy,
	input  wire iad_req_t   request,
	input  wire logic       done,
	input  wire iad_res_t   result,
	output int              mismatches,
	output int              pending,
	output logic [POS_W-1:0] array_length
);

	word_t    store [DEPTH];
	int       fill;
	iad_res_t awaited_results [$];
	iad_res_t oldest;

	function automatic iad_res_t execute_command(input iad_req_t r);
		iad_res_t res;
		word_t    v;
		int       p;
		int       i;
		res = '0;
		res.status = ST_OK;
		v = word_t'(r.value);
		p = int'(r.position);
		case (r.command)
		CMD_READ: begin
			if (p < fill)
				res.read_data = DATA_W'($signed(store[p]));
			else
				res.status = ST_RANGE;
		end
		CMD_WRITE: begin
			if (p < fill)
				store[p] = v;
			else
				res.status = ST_RANGE;
		end
		CMD_INSERT: begin
			if (p > fill) begin
				res.status = ST_RANGE;
			end else if (fill >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				for (i = fill; i > p; i--)
					store[i] = store[i - 1];
				store[p] = v;
				fill++;
			end
		end
		CMD_DELETE: begin
			if (p < fill) begin
				for (i = p; i + 1 < fill; i++)
					store[i] = store[i + 1];
				fill--;
			end else begin
				res.status = ST_RANGE;
			end
		end
		CMD_RESIZE: begin
			if (int'(r.new_length) <= DEPTH)
				fill = int'(r.new_length);
			else
				res.status = ST_RANGE;
		end
		default: begin
			res.status = ST_RANGE;
		end
		endcase
		res.length = POS_W'(fill);
		return res;
	endfunction

	task automatic report(input string field, input logic [DATA_W-1:0] exp_val,
			input logic [DATA_W-1:0] act_val);
		mismatches++;
		$display("%0t: %s expected %0h got %0h", $time, field, exp_val, act_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (store[k])
				store[k] = '0;
			fill = 0;
			awaited_results.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					report("unexpected item", '0, result.read_data);
				end else begin
					oldest = awaited_results.pop_front();
					if (result.read_data !== oldest.read_data)
						report("read_data", oldest.read_data, result.read_data);
					if (result.status !== oldest.status)
						report("status", DATA_W'(oldest.status), DATA_W'(result.status));
					if (result.length !== oldest.length)
						report("length", DATA_W'(oldest.length), DATA_W'(result.length));
				end
			end
			if (start && !busy)
				awaited_results.push_back(execute_command(request));
		end
		pending = awaited_results.size();
		array_length = POS_W'(fill);
	end

endmodule

`default_nettype wire

// ===== dv/indexed_array_insert_delete_tb.sv =====
`default_nettype none

module indexed_array_insert_delete_tb
	import iad_pkg::*;
;

	localparam int HALF_PERIOD  = 6;
	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASE_ITEMS  = 150;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	iad_req_t         request;
	logic             done;
	iad_res_t         result;
	int               mismatches;
	int               pending;
	logic [POS_W-1:0] array_length;
	int               burst_left;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	indexed_array_insert_delete DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	iad_array_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.done         (done),
		.result       (result),
		.mismatches   (mismatches),
		.pending      (pending),
		.array_length (array_length)
	);

	function automatic iad_req_t noise_request();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(iad_req_t)-1:0];
	endfunction

	function automatic iad_req_t make_req(input logic [CMD_W-1:0] cmd, input int pos,
			input logic [DATA_W-1:0] val, input int nlen);
		iad_req_t r;
		r.command    = cmd;
		r.position   = POS_W'(pos);
		r.value      = val;
		r.new_length = POS_W'(nlen);
		return r;
	endfunction

	function automatic iad_req_t random_item(input bit grow);
		int               len;
		int               roll;
		int               pos;
		int               nlen;
		logic [CMD_W-1:0] cmd;
		logic [DATA_W-1:0] val;
		len = int'(array_length);
		case ($urandom_range(0, 7))
		0: val = 32'h8000_0000;
		1: val = 32'h7FFF_FFFF;
		2: val = 32'hFFFF_FFFF;
		3: val = 32'h0;
		default: val = $urandom();
		endcase
		if ($urandom_range(0, 99) < 5)
			return noise_request();
		roll = $urandom_range(0, 99);
		if (grow)
			cmd = roll < 45 ? CMD_INSERT : roll < 55 ? CMD_DELETE : roll < 75 ? CMD_READ :
				roll < 93 ? CMD_WRITE : CMD_RESIZE;
		else
			cmd = roll < 12 ? CMD_INSERT : roll < 50 ? CMD_DELETE : roll < 72 ? CMD_READ :
				roll < 93 ? CMD_WRITE : CMD_RESIZE;
		if (cmd == CMD_INSERT)
			pos = $urandom_range(0, len);
		else
			pos = (len > 0) ? $urandom_range(0, len - 1) : 0;
		if ($urandom_range(0, 9) == 0)
			pos = $urandom_range(len, 127);
		if ($urandom_range(0, 3) == 0)
			nlen = $urandom_range(0, 1) ? DEPTH : 0;
		else
			nlen = $urandom_range(0, DEPTH);
		if ($urandom_range(0, 9) == 0)
			nlen = $urandom_range(DEPTH + 1, 127);
		return make_req(cmd, pos, val, nlen);
	endfunction

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start   <= 1'b0;
			request <= noise_request();
		end
	endtask

	task automatic issue(input iad_req_t r);
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_cycles(($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		end
	endtask

	initial begin
		#(2 * HALF_PERIOD * 200000);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		request    = '0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty array: every position is out of range, insert beyond length too
		issue(make_req(CMD_READ, 0, $urandom(), 127));
		issue(make_req(CMD_DELETE, 0, $urandom(), 0));
		issue(make_req(CMD_WRITE, 0, 32'hFFFF_FFFF, 64));
		issue(make_req(CMD_INSERT, 1, 32'h1234_5678, 0));
		issue(make_req(CMD_INSERT, 0, 32'h7FFF_FFFF, 0));
		issue(make_req(CMD_INSERT, 1, 32'h8000_0000, 127));
		issue(make_req(CMD_INSERT, 0, 32'hFFFF_FFFF, 0));
		issue(make_req(CMD_READ, 0, 32'h0, 0));
		issue(make_req(CMD_READ, 2, 32'h0, 0));
		issue(make_req(CMD_WRITE, 1, 32'h0, 0));
		issue(make_req(CMD_DELETE, 1, 32'hFFFF_FFFF, 127));
		issue(make_req(CMD_READ, 1, 32'h0, 0));
		// grow again: the vacated slot reappears
		issue(make_req(CMD_RESIZE, 0, 32'h0, DEPTH));
		issue(make_req(CMD_READ, 2, 32'h0, 0));
		issue(make_req(CMD_READ, DEPTH - 1, 32'h0, 0));
		issue(make_req(CMD_INSERT, DEPTH, 32'h5555_5555, 0));
		issue(make_req(CMD_INSERT, DEPTH + 1, 32'hAAAA_AAAA, 0));
		issue(make_req(CMD_READ, DEPTH, 32'h0, 0));
		issue(make_req(CMD_RESIZE, 127, 32'h0, DEPTH + 1));
		issue(make_req(CMD_RESIZE, 0, 32'h0, 127));
		for (int c = CMD_RESIZE + 1; c < 2 ** CMD_W; c++)
			issue(make_req(CMD_W'(c), $urandom_range(0, 127), $urandom(),
				$urandom_range(0, 127)));
		issue(make_req(CMD_RESIZE, 127, 32'hFFFF_FFFF, 0));
		issue(make_req(CMD_DELETE, 0, 32'h0, 0));

		for (int n = 0; n < RANDOM_ITEMS; n++)
			issue(random_item(((n / PHASE_ITEMS) % 2) == 0));

		@(negedge clk);
		start <= 1'b0;
		for (int w = 0; w < 50 && pending != 0; w++)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
